/* hdl/bitmap_allocator_first_free_assert.svh */
// assertion macros shared by the bitmap allocator modules
`ifndef BITMAP_ALLOCATOR_FIRST_FREE_ASSERT_SVH
`define BITMAP_ALLOCATOR_FIRST_FREE_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked on every clock edge outside reset
`define BMA_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("bitmap allocator assertion failed");
// condition in one cycle implies a condition in the next
`define BMA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bitmap allocator assertion failed");
`else
`define BMA_ASSERT(lbl, prop)
`define BMA_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

/* hdl/bma_pkg.sv */
// shared constants, codes and types of the bitmap allocator
package bma_pkg;

    // map geometry
    localparam int MAX_BITS   = 4096;
    localparam int WORD_BITS  = 64;
    localparam int WORD_SLOTS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WADDR_W    = $clog2(WORD_SLOTS);
    localparam int PTR_W      = WADDR_W + 1;
    localparam int IDX_W      = 12;
    localparam int SIZE_W     = 13;

    // byte split of the trailing-ones search
    localparam int BYTE_BITS  = 8;
    localparam int BYTE_COUNT = WORD_BITS / BYTE_BITS;
    localparam int SEL_W      = $clog2(BYTE_COUNT);
    localparam int TZ_W       = $clog2(BYTE_BITS);

    // action codes
    typedef logic [1:0] t_action;
    localparam t_action ACT_READ  = 2'd0;
    localparam t_action ACT_SET   = 2'd1;
    localparam t_action ACT_CLEAR = 2'd2;

    // controller states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MOD  = 5'b00010,
        S_SCAN = 5'b00100,
        S_TZ1  = 5'b01000,
        S_TZ2  = 5'b10000
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start;
        logic modify;
        logic scan;
        logic stage;
        logic load;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic err_now;
        logic scan_go;
        logic scan_more;
    } t_status;

endpackage

/* hdl/bma_ctrl.sv */
// sequencing controller of the bitmap allocator
module bma_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    input  bma_pkg::t_status i_status,
    output bma_pkg::t_cmd    o_cmd
);
    import bma_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   ready;
    logic   accept;

    // handshake decode
    assign out_free = !r_out_valid || !i_out_stall;
    assign ready    = (r_state == S_IDLE) || ((r_state == S_TZ2) && out_free);
    assign accept   = i_in_valid && ready;

    assign o_in_stall  = !ready;
    assign o_out_valid = r_out_valid;

    // datapath commands
    always_comb begin
        o_cmd.start  = accept;
        o_cmd.modify = (r_state == S_MOD);
        o_cmd.scan   = (r_state == S_SCAN);
        o_cmd.stage  = (r_state == S_TZ1);
        o_cmd.load   = (r_state == S_TZ2) && out_free;
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_status.err_now ? S_TZ1 : S_MOD;
                end
            end
            S_MOD: begin
                n_state = i_status.scan_go ? S_SCAN : S_TZ1;
            end
            S_SCAN: begin
                n_state = i_status.scan_more ? S_SCAN : S_TZ1;
            end
            S_TZ1: begin
                n_state = S_TZ2;
            end
            S_TZ2: begin
                if (accept) begin
                    n_state = i_status.err_now ? S_TZ1 : S_MOD;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output transaction valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // checks
    `include "bitmap_allocator_first_free_assert.svh"
    `BMA_ASSERT(a_out_from_finish, $rose(r_out_valid) |-> $past(r_state == S_TZ2))
    `BMA_ASSERT_NEXT(a_modify_moves_on, r_state == S_MOD, r_state == S_SCAN || r_state == S_TZ1)
    `BMA_ASSERT_NEXT(a_error_skips_modify, o_cmd.start && i_status.err_now, r_state == S_TZ1)

endmodule

/* hdl/bma_datapath.sv */
// word store, pointer, scan and lowest-free search of the bitmap allocator
module bma_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bma_pkg::SIZE_W-1:0]   i_cfg_data,
    input  bma_pkg::t_action             i_action,
    input  logic [bma_pkg::IDX_W-1:0]    i_index,
    input  bma_pkg::t_cmd                i_cmd,
    output bma_pkg::t_status             o_status,
    output logic                         o_bit_value,
    output logic [bma_pkg::IDX_W-1:0]    o_free_index,
    output logic                         o_free_found,
    output logic                         o_range_error
);
    import bma_pkg::*;

    // word count of a size, rounded up
    function automatic logic [PTR_W-1:0] word_len(input logic [SIZE_W-1:0] s);
        logic [SIZE_W:0] sum;
        sum = {1'b0, s} + (SIZE_W+1)'(WORD_BITS - 1);
        return PTR_W'(sum[SIZE_W:BIT_W]);
    endfunction

    // bits of the last word that lie inside a size
    function automatic logic [WORD_BITS-1:0] last_mask(input logic [SIZE_W-1:0] s);
        logic [WORD_BITS-1:0] m;
        if (s[BIT_W-1:0] == '0) begin
            m = '1;
        end else begin
            m = ~({WORD_BITS{1'b1}} << s[BIT_W-1:0]);
        end
        return m;
    endfunction

    // store and its valid bits
    logic [WORD_BITS-1:0]  r_mem [WORD_SLOTS];
    logic [WORD_SLOTS-1:0] r_vld;
    logic [WORD_BITS-1:0]  r_rdata;
    logic                  r_rd_vld;

    // size registers
    logic [SIZE_W-1:0]    r_size;
    logic [PTR_W-1:0]     r_len;
    logic [PTR_W-1:0]     r_len_m1;
    logic [WORD_BITS-1:0] r_last_mask;

    // current transaction
    t_action            r_action;
    logic [IDX_W-1:0]   r_index;
    logic               r_err;
    logic               r_bitv;
    logic [PTR_W-1:0]   r_fow;
    logic [WADDR_W-1:0] r_scan;

    // search stage
    logic [WORD_BITS-1:0]  r_tz_word;
    logic [BYTE_COUNT-1:0] r_tz_full;

    // result register
    logic             r_out_bit;
    logic [IDX_W-1:0] r_out_fidx;
    logic             r_out_found;
    logic             r_out_err;

    logic [SIZE_W-1:0]    cfg_sat;
    logic [WORD_BITS-1:0] word_q;
    logic                 err_now;
    logic [WADDR_W-1:0]   w;
    logic [BIT_W-1:0]     b;
    logic [WORD_BITS-1:0] bit_mask;
    logic [WORD_BITS-1:0] new_word;
    logic                 we;
    logic [PTR_W-1:0]     st_pos;
    logic [WORD_BITS-1:0] st_word;
    logic                 st_last;
    logic                 st_full;
    logic                 st_more;
    logic [PTR_W-1:0]     st_end;
    logic                 touch_first;
    logic                 scan_go;
    logic [PTR_W-1:0]     fow_next;
    logic [WADDR_W-1:0]   rd_addr;
    logic [SEL_W-1:0]     sel;
    logic                 all_full;
    logic [BYTE_BITS-1:0] sel_byte;
    logic [TZ_W-1:0]      tz;
    logic [BIT_W:0]       ones;
    logic [SIZE_W-1:0]    pos;
    logic                 found;

    // operand decode
    assign cfg_sat  = (i_cfg_data > SIZE_W'(MAX_BITS)) ? SIZE_W'(MAX_BITS) : i_cfg_data;
    assign word_q   = r_rd_vld ? r_rdata : '0;
    assign err_now  = {1'b0, i_index} >= r_size;
    assign w        = r_index[IDX_W-1:BIT_W];
    assign b        = r_index[BIT_W-1:0];
    assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << b;

    // modified word
    always_comb begin
        case (r_action)
            ACT_READ:  new_word = word_q;
            ACT_SET:   new_word = word_q | bit_mask;
            ACT_CLEAR: new_word = word_q & ~bit_mask;
            default:   new_word = word_q;
        endcase
    end

    assign we = i_cmd.modify && ((r_action == ACT_SET) || (r_action == ACT_CLEAR));

    // one step of the forward scan over full words
    assign st_pos  = i_cmd.scan ? {1'b0, r_scan} : {1'b0, w};
    assign st_word = i_cmd.scan ? word_q : new_word;
    assign st_last = (st_pos == r_len_m1);
    assign st_full = st_last ? ((st_word & r_last_mask) == r_last_mask) : (&st_word);
    assign st_more = !st_last && st_full;
    assign st_end  = (st_last && st_full) ? r_len : st_pos;

    assign touch_first = (r_action == ACT_SET) && ({1'b0, w} == r_fow);
    assign scan_go     = touch_first && st_more;

    // pointer update
    always_comb begin
        fow_next = r_fow;
        if (i_cmd.scan) begin
            fow_next = st_end;
        end else if (touch_first) begin
            fow_next = st_end;
        end else if ((r_action == ACT_CLEAR) && ({1'b0, w} < r_fow)) begin
            fow_next = {1'b0, w};
        end
    end

    always_comb begin
        o_status.err_now   = err_now;
        o_status.scan_go   = i_cmd.modify && scan_go;
        o_status.scan_more = i_cmd.scan && st_more;
    end

    // read address select
    always_comb begin
        if (i_cmd.start) begin
            rd_addr = err_now ? r_fow[WADDR_W-1:0] : i_index[IDX_W-1:BIT_W];
        end else if (i_cmd.modify) begin
            rd_addr = scan_go ? (w + WADDR_W'(1)) : fow_next[WADDR_W-1:0];
        end else if (i_cmd.scan) begin
            rd_addr = st_more ? (r_scan + WADDR_W'(1)) : fow_next[WADDR_W-1:0];
        end else begin
            rd_addr = r_fow[WADDR_W-1:0];
        end
    end

    // word store with write-through read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[w] <= new_word;
        end
        if (we && (w == rd_addr)) begin
            r_rdata <= new_word;
        end else begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    // valid bits, cleared by reset and by a size write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= (we && (w == rd_addr)) || r_vld[rd_addr];
            if (i_cfg_we) begin
                r_vld <= '0;
            end else if (we) begin
                r_vld[w] <= 1'b1;
            end
        end
    end

    // size and first open word pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size      <= SIZE_W'(MAX_BITS);
            r_len       <= word_len(SIZE_W'(MAX_BITS));
            r_len_m1    <= word_len(SIZE_W'(MAX_BITS)) - PTR_W'(1);
            r_last_mask <= last_mask(SIZE_W'(MAX_BITS));
            r_fow       <= '0;
        end else if (i_cfg_we) begin
            r_size      <= cfg_sat;
            r_len       <= word_len(cfg_sat);
            r_len_m1    <= word_len(cfg_sat) - PTR_W'(1);
            r_last_mask <= last_mask(cfg_sat);
            r_fow       <= '0;
        end else if ((i_cmd.modify && !scan_go) || (i_cmd.scan && !st_more)) begin
            r_fow <= fow_next;
        end
    end

    // transaction operands and scan position
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_action <= i_action;
            r_index  <= i_index;
            r_err    <= err_now;
            r_bitv   <= 1'b0;
        end
        if (i_cmd.modify) begin
            r_bitv <= new_word[b];
            r_scan <= w + WADDR_W'(1);
        end else if (i_cmd.scan) begin
            r_scan <= r_scan + WADDR_W'(1);
        end
    end

    // first search stage: full flag per byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.stage) begin
            r_tz_word <= word_q;
            for (int k = 0; k < BYTE_COUNT; k++) begin
                r_tz_full[k] <= &word_q[k*BYTE_BITS +: BYTE_BITS];
            end
        end
    end

    // second search stage: lowest open byte, then trailing ones in it
    always_comb begin
        sel = '0;
        for (int k = BYTE_COUNT - 1; k >= 0; k--) begin
            if (!r_tz_full[k]) begin
                sel = SEL_W'(k);
            end
        end
        all_full = &r_tz_full;
        sel_byte = r_tz_word[sel*BYTE_BITS +: BYTE_BITS];
        tz = '0;
        for (int j = BYTE_BITS - 1; j >= 0; j--) begin
            if (!sel_byte[j]) begin
                tz = TZ_W'(j);
            end
        end
        ones  = all_full ? (BIT_W+1)'(WORD_BITS) : {1'b0, sel, tz};
        pos   = {1'b0, r_fow[WADDR_W-1:0], {BIT_W{1'b0}}} + SIZE_W'(ones);
        found = (r_fow < r_len) && (pos < r_size);
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_bit   <= r_bitv;
            r_out_fidx  <= found ? pos[IDX_W-1:0] : '0;
            r_out_found <= found;
            r_out_err   <= r_err;
        end
    end

    assign o_bit_value   = r_out_bit;
    assign o_free_index  = r_out_fidx;
    assign o_free_found  = r_out_found;
    assign o_range_error = r_out_err;

    // checks
    `include "bitmap_allocator_first_free_assert.svh"
    `BMA_ASSERT(a_fow_in_range, r_fow <= r_len)
    `BMA_ASSERT(a_scan_in_map, i_cmd.scan |-> (PTR_W'(r_scan) < r_len))
    `BMA_ASSERT(a_no_write_on_error, we |-> !r_err)

endmodule

/* hdl/bitmap_allocator_first_free.sv */
// top level of the first-free bitmap allocator
//
//   channel  handshake                  payload
//   in       i_in_valid / o_in_stall    i_action, i_index
//   out      o_out_valid / i_out_stall  o_bit_value, o_free_index, o_free_found, o_range_error
//   cfg      i_cfg_we                   i_cfg_data (bit_count)
//
// a read, a clear or a set that needs no scan passes the modify state and both
// search stages, an out-of-range index the search stages alone; a set that fills
// the first open word below the last word adds a scan step for each following word
// the scan reads, the full ones and the one it stops at (one store read per cycle).
// the store of 64 words has a valid bit per word, so reset and a bit_count
// write clear the map at once; no clearing pass.
// a result waits in the output register under stall; the next transaction is
// taken in the cycle the result is loaded, and none while a result cannot be.
module bitmap_allocator_first_free (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bma_pkg::SIZE_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  bma_pkg::t_action            i_action,
    input  logic [bma_pkg::IDX_W-1:0]   i_index,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_bit_value,
    output logic [bma_pkg::IDX_W-1:0]   o_free_index,
    output logic                        o_free_found,
    output logic                        o_range_error
);
    import bma_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencing
    bma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // store and search
    bma_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_action      (i_action),
        .i_index       (i_index),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_bit_value   (o_bit_value),
        .o_free_index  (o_free_index),
        .o_free_found  (o_free_found),
        .o_range_error (o_range_error)
    );

endmodule

/* verif/bma_result_check.sv */
// result checker of the first-free bitmap allocator: prediction and comparison
module bma_result_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [bma_pkg::SIZE_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  bma_pkg::t_action           i_action,
    input  logic [bma_pkg::IDX_W-1:0]  i_index,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic                       i_bit_value,
    input  logic [bma_pkg::IDX_W-1:0]  i_free_index,
    input  logic                       i_free_found,
    input  logic                       i_range_error,
    output int                         o_fail_count,
    output int                         o_pending
);
    import bma_pkg::*;

    // one result transaction
    typedef struct packed {
        logic             bit_value;
        logic [IDX_W-1:0] free_index;
        logic             free_found;
        logic             range_error;
    } t_alloc_result;

    // shadow copy of the map, pointer and size register
    logic [WORD_BITS-1:0] mark_map [WORD_SLOTS];
    int                   open_word;
    logic [SIZE_W-1:0]    size_reg;

    // results still owed by the block, oldest first
    t_alloc_result        alloc_results_q [$];
    int                   fail_total = 0;

    assign o_fail_count = fail_total;

    // size in use, saturated to the map capacity
    function automatic int map_size();
        return (size_reg > MAX_BITS) ? MAX_BITS : int'(size_reg);
    endfunction

    // count of set bits below the first clear bit
    function automatic int low_ones(logic [WORD_BITS-1:0] w);
        int n;
        n = 0;
        while (n < WORD_BITS && w[n])
            n++;
        return n;
    endfunction

    // fresh map, pointer back to the first word
    function automatic void clear_map();
        foreach (mark_map[i])
            mark_map[i] = '0;
        open_word = 0;
    endfunction

    // apply one access to the shadow map and work out its result
    function automatic t_alloc_result apply_access(t_action act, logic [IDX_W-1:0] idx);
        t_alloc_result res;
        int            size;
        int            len;
        int            w;
        int            b;
        int            c;
        int            last_bits;
        int            pos;
        res  = '0;
        size = map_size();
        len  = (size + WORD_BITS - 1) / WORD_BITS;
        if (int'(idx) >= size) begin
            res.range_error = 1'b1;
        end else begin
            w = int'(idx) / WORD_BITS;
            b = int'(idx) % WORD_BITS;
            if (act == ACT_SET) begin
                mark_map[w][b] = 1'b1;
                // filling the open word moves the pointer past full words
                if (w == open_word) begin
                    c         = w;
                    last_bits = size % WORD_BITS;
                    if (last_bits == 0)
                        last_bits = WORD_BITS;
                    while (c < len - 1 && (&mark_map[c]))
                        c++;
                    if (c == len - 1 && $countones(mark_map[c]) == last_bits)
                        c++;
                    open_word = c;
                end
            end else if (act == ACT_CLEAR) begin
                mark_map[w][b] = 1'b0;
                if (w < open_word)
                    open_word = w;
            end
            res.bit_value = mark_map[w][b];
        end
        // lowest clear position from the open word
        if (open_word < len && open_word < WORD_SLOTS) begin
            pos = WORD_BITS * open_word + low_ones(mark_map[open_word]);
            if (pos < size) begin
                res.free_found = 1'b1;
                res.free_index = pos[IDX_W-1:0];
            end
        end
        return res;
    endfunction

    // one line per mismatch, every one counted
    task automatic report_miss(string what, int got_v, int want_v);
        $display("bitmap allocator: %s got %0d expected %0d at %0t",
                 what, got_v, want_v, $time);
        fail_total++;
    endtask

    // watch the channels at each edge
    always @(posedge i_clk) begin : watch_channels
        t_alloc_result got;
        t_alloc_result want;
        if (!i_rst_n) begin
            clear_map();
            size_reg = SIZE_W'(MAX_BITS);
            alloc_results_q.delete();
        end else begin
            // result transaction against the oldest expectation
            if (i_out_valid && !i_out_stall) begin
                got.bit_value   = i_bit_value;
                got.free_index  = i_free_index;
                got.free_found  = i_free_found;
                got.range_error = i_range_error;
                if (alloc_results_q.size() == 0) begin
                    report_miss("result with nothing outstanding", 1, 0);
                end else begin
                    want = alloc_results_q.pop_front();
                    if (got.bit_value !== want.bit_value)
                        report_miss("bit_value", int'(got.bit_value),
                                    int'(want.bit_value));
                    if (got.free_index !== want.free_index)
                        report_miss("free_index", int'(got.free_index),
                                    int'(want.free_index));
                    if (got.free_found !== want.free_found)
                        report_miss("free_found", int'(got.free_found),
                                    int'(want.free_found));
                    if (got.range_error !== want.range_error)
                        report_miss("range_error", int'(got.range_error),
                                    int'(want.range_error));
                end
            end
            // size write starts a fresh map
            if (i_cfg_we) begin
                size_reg = i_cfg_data;
                clear_map();
            end
            // accepted access transaction
            if (i_in_valid && !i_in_stall)
                alloc_results_q.push_back(apply_access(i_action, i_index));
        end
        o_pending <= alloc_results_q.size();
    end

endmodule

/* verif/tb_top.sv */
// testbench top of the first-free bitmap allocator: stimulus and verdict
module tb_top;
    import bma_pkg::*;

    localparam t_action ACT_SPARE   = 2'd3;
    localparam int      CYCLE_LIMIT = 1000000;
    localparam int      HOLD_CYCLES = 60;
    localparam int      TAIL_CYCLES = 80;
    localparam int      PHASES      = 11;

    logic               i_clk        = 1'b0;
    logic               i_rst_n      = 1'b0;
    logic               i_cfg_we     = 1'b0;
    logic [SIZE_W-1:0]  i_cfg_data   = '0;
    logic               i_in_valid   = 1'b0;
    logic               o_in_stall;
    t_action            i_action     = ACT_READ;
    logic [IDX_W-1:0]   i_index      = '0;
    logic               o_out_valid;
    logic               i_out_stall  = 1'b0;
    logic               o_bit_value;
    logic [IDX_W-1:0]   o_free_index;
    logic               o_free_found;
    logic               o_range_error;

    int                 fail_count;
    int                 pending;
    int                 cycles       = 0;
    bit                 quiet        = 1'b0;
    bit                 hold_req     = 1'b0;
    int                 gap_pct      = 0;
    int                 stall_pct    = 0;

    // phase plan: size written (-1 for a random small one), item count,
    // share of sequential fill sets, sender and receiver idling
    int phase_size  [PHASES] = '{64, 1, 200, 0, 65, 8191, 600, 127, 4096, -1, 128};
    int phase_items [PHASES] = '{120, 40, 200, 40, 150, 150, 700, 150, 150, 100, 100};
    int phase_fill  [PHASES] = '{70, 40, 50, 0, 70, 40, 92, 60, 50, 60, 60};
    int phase_gap   [PHASES] = '{20, 35, 0, 20, 35, 20, 10, 0, 25, 20, 0};
    int phase_stall [PHASES] = '{25, 40, 20, 0, 30, 25, 15, 0, 35, 25, 0};

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    bitmap_allocator_first_free DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_index       (i_index),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_bit_value   (o_bit_value),
        .o_free_index  (o_free_index),
        .o_free_found  (o_free_found),
        .o_range_error (o_range_error)
    );

    bma_result_check u_result_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_action      (i_action),
        .i_index       (i_index),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_bit_value   (o_bit_value),
        .i_free_index  (o_free_index),
        .i_free_found  (o_free_found),
        .i_range_error (o_range_error),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("bitmap_allocator_first_free: mismatch");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin : result_sink
        int held;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_out_stall <= 1'b1;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    held++;
                end
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(99, 0) < stall_pct) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(3, 1)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge i_clk);
            end
        end
    end

    // offer one access transaction and wait until it is taken
    task automatic offer(input t_action act, input logic [IDX_W-1:0] idx);
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_index    <= idx;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        if (!quiet && $urandom_range(99, 0) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
    endtask

    // stop offering until every owed result has come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // size write on an idle block
    task automatic write_size(input logic [SIZE_W-1:0] val);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // edges of the index range, every action, full and empty maps
    task automatic run_directed();
        // reset size of 4096
        offer(ACT_READ, 12'd0);
        offer(ACT_SET, 12'd0);
        offer(ACT_READ, 12'd0);
        offer(ACT_SET, 12'd4095);
        offer(ACT_READ, 12'd4095);
        offer(ACT_SPARE, 12'd4095);
        offer(ACT_CLEAR, 12'd4095);
        offer(ACT_SET, 12'd1);
        offer(ACT_CLEAR, 12'd0);
        offer(ACT_SET, 12'd0);
        offer(ACT_CLEAR, 12'd2);
        offer(ACT_READ, 12'd2048);
        // one-bit map: full after one set, out of range beyond it
        write_size(13'd1);
        offer(ACT_SET, 12'd0);
        offer(ACT_READ, 12'd0);
        offer(ACT_SPARE, 12'd0);
        offer(ACT_SET, 12'd1);
        offer(ACT_CLEAR, 12'd4095);
        offer(ACT_CLEAR, 12'd0);
        // empty map: everything out of range
        write_size(13'd0);
        offer(ACT_READ, 12'd0);
        offer(ACT_SET, 12'd4095);
        // one full word
        write_size(13'd64);
        offer(ACT_SET, 12'd63);
        offer(ACT_READ, 12'd64);
    endtask

    // random phase: sequential fill sets with clears, reads and noise
    task automatic run_phase(input int size_val, input int count, input int fill_pct,
                             input bit hold, input bit pause);
        int               eff;
        int               cursor;
        int               r;
        t_action          act;
        logic [IDX_W-1:0] idx;
        write_size(size_val[SIZE_W-1:0]);
        eff    = (size_val > MAX_BITS) ? MAX_BITS : size_val;
        cursor = (eff > 1) ? 1 : 0;
        for (int k = 0; k < count; k++) begin
            if (hold && k == 20)
                hold_req = 1'b1;
            if (pause && k == count / 2)
                drain();
            r = $urandom_range(99, 0);
            if (eff == 0 || r < 8) begin
                // any action code, any index
                act = t_action'($urandom_range(3, 0));
                idx = IDX_W'($urandom);
                if (r == 0 && eff > 0 && eff < MAX_BITS)
                    idx = IDX_W'(eff);
            end else if (r < 8 + fill_pct) begin
                // allocate in order so whole words fill and the pointer scans
                act    = ACT_SET;
                idx    = IDX_W'(cursor);
                cursor = (cursor + 1) % eff;
            end else begin
                idx = IDX_W'($urandom_range(eff - 1, 0));
                case (r % 3)
                    0: begin
                        act = ACT_CLEAR;
                    end
                    1: begin
                        act = ACT_READ;
                    end
                    default: begin
                        act = ACT_SET;
                    end
                endcase
            end
            offer(act, idx);
        end
    endtask

    // main sequence
    initial begin : stimulus
        int size_val;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            gap_pct   = phase_gap[p];
            stall_pct = phase_stall[p];
            quiet     = (p == PHASES - 1);
            size_val  = (phase_size[p] < 0) ? $urandom_range(300, 2) : phase_size[p];
            run_phase(size_val, phase_items[p], phase_fill[p], p == 2, p == 4);
        end
        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("bitmap_allocator_first_free: match");
        else
            $display("bitmap_allocator_first_free: mismatch");
        $finish;
    end

endmodule
